// ===== hdl/msscl_pkg.sv =====
// Shared types and constants for the memory sample source classifier.
// No dependencies; the design modules refer to it by scoped name, the testbench files import it.
`timescale 1ns / 1ps
`default_nettype none

package msscl_pkg;

  localparam int unsigned CNT_W   = 48;
  localparam int unsigned NUM_CNT = 25;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       inc_t;
  typedef logic [4:0]       ridx_t;

  // Event counter slots
  localparam int unsigned C_ENTRIES   = 0;
  localparam int unsigned C_LOCKS     = 1;
  localparam int unsigned C_LOAD      = 2;
  localparam int unsigned C_LD_NOADDR = 3;
  localparam int unsigned C_LD_UNC    = 4;
  localparam int unsigned C_LD_IO     = 5;
  localparam int unsigned C_LD_LFB    = 6;
  localparam int unsigned C_LD_L1     = 7;
  localparam int unsigned C_LD_L2     = 8;
  localparam int unsigned C_LCL_HITM  = 9;
  localparam int unsigned C_LD_LLC    = 10;
  localparam int unsigned C_LCL_DRAM  = 11;
  localparam int unsigned C_LD_SHARED = 12;
  localparam int unsigned C_LD_EXCL   = 13;
  localparam int unsigned C_RMT_DRAM  = 14;
  localparam int unsigned C_RMT_HIT   = 15;
  localparam int unsigned C_RMT_HITM  = 16;
  localparam int unsigned C_LD_MISS   = 17;
  localparam int unsigned C_STORE     = 18;
  localparam int unsigned C_ST_NOADDR = 19;
  localparam int unsigned C_ST_UNC    = 20;
  localparam int unsigned C_ST_L1HIT  = 21;
  localparam int unsigned C_ST_L1MISS = 22;
  localparam int unsigned C_NOPARSE   = 23;
  localparam int unsigned C_NOMAP     = 24;

  // Read indexes beyond the counter bank
  localparam ridx_t RD_PERIOD = 5'd25;
  localparam ridx_t RD_TOTAL  = 5'd26;
  localparam ridx_t RD_HITM   = 5'd27;
  localparam ridx_t RD_MISSDN = 5'd28;

  // Operation codes on func
  localparam logic FN_RECORD = 1'b0;
  localparam logic FN_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOADDR  = 2'd1,
    ST_NOPARSE = 2'd2,
    ST_NOMAP   = 2'd3
  } status_t;

  typedef struct packed {
    logic                   is_read;
    ridx_t                  read_index;
    logic [31:0]            period;
    status_t                status;
    inc_t [NUM_CNT-1:0]     inc;
    logic [2:0]             inc_total;
    logic [1:0]             inc_hitm;
    logic [1:0]             inc_missdn;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== hdl/msscl_ifs.sv =====
// Channel interfaces: sample input and result output, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface msscl_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [4:0]  op_bits;
  logic [13:0] level_bits;
  logic [4:0]  snoop_bits;
  logic [1:0]  lock_bits;
  logic        addr_known;
  logic        maps_known;
  logic [31:0] sample_period;
  logic [4:0]  read_index;

  modport source (
    output valid, func, op_bits, level_bits, snoop_bits, lock_bits,
           addr_known, maps_known, sample_period, read_index,
    input  ready
  );
  modport sink (
    input  valid, func, op_bits, level_bits, snoop_bits, lock_bits,
           addr_known, maps_known, sample_period, read_index,
    output ready
  );
endinterface

interface msscl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] read_value;

  modport source (output valid, status, read_value, input ready);
  modport sink (input valid, status, read_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/memory_sample_source_classifier_core.sv =====
// Top level of the memory sample source classifier.
// Depends on msscl_pkg, msscl_ifs, msscl_front, msscl_queue, msscl_back.
//
//   channel  dir  payload                                         accept
//   samp     in   func, op/level/snoop/lock flags, addr/maps,     valid && ready
//                 sample_period, read_index
//   res      out  status, read_value                              valid && ready
//
// One item per cycle sustained while the result sink keeps taking results; an accepted item
// is written to the queue at the accepting edge, and its counter update and output register
// load happen at the edge at which the counter bank pops it from the queue.
// The front end accepts while the four-entry queue has room; the counter bank
// drains it whenever the output register is empty or being taken.
// Synchronous reset clears all counters, sums, the queue and the output valid.

`timescale 1ns / 1ps
`default_nettype none

module memory_sample_source_classifier_core (
  input  logic          clk,
  input  logic          rst,
  msscl_in_if.sink      samp,
  msscl_out_if.source   res
);

  logic                 q_push;
  logic                 q_ready;
  msscl_pkg::q_entry_t  q_in;
  logic                 q_pop;
  logic                 q_valid;
  msscl_pkg::q_entry_t  q_head;

  msscl_front u_front (
    .samp    (samp),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  msscl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_head)
  );

  msscl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire

// ===== hdl/msscl_front.sv =====
// Front end: accepts items and decodes the flag groups into counter increments.
// Depends on msscl_pkg and msscl_in_if.
`timescale 1ns / 1ps
`default_nettype none

module msscl_front (
  msscl_in_if.sink              samp,
  input  logic                  q_ready,
  output logic                  q_push,
  output msscl_pkg::q_entry_t   q_entry
);

  logic        is_load;
  logic        is_store;
  logic        hit;
  logic        lcl_ram;
  logic        rmt_ram;
  logic [1:0]  ram_hits;
  msscl_pkg::inc_t [msscl_pkg::NUM_CNT-1:0] inc;

  assign samp.ready = q_ready;
  assign q_push     = samp.valid;

  always_comb begin
    is_load  = samp.op_bits[1];
    is_store = !samp.op_bits[1] && samp.op_bits[2];
    hit      = samp.level_bits[1];
    lcl_ram  = hit && samp.level_bits[7];
    rmt_ram  = hit && (samp.level_bits[9:8] != 2'b00);
    ram_hits = {1'b0, lcl_ram} + {1'b0, rmt_ram};

    inc = '0;
    q_entry.status = msscl_pkg::ST_OK;

    inc[msscl_pkg::C_ENTRIES] = 2'd1;
    inc[msscl_pkg::C_LOCKS]   = {1'b0, samp.lock_bits[1]};

    if (is_load) begin
      inc[msscl_pkg::C_LOAD] = 2'd1;
      if (!samp.addr_known) begin
        inc[msscl_pkg::C_LD_NOADDR] = 2'd1;
        q_entry.status = msscl_pkg::ST_NOADDR;
      end else begin
        if (hit) begin
          inc[msscl_pkg::C_LD_UNC] = {1'b0, samp.level_bits[13]};
          inc[msscl_pkg::C_LD_IO]  = {1'b0, samp.level_bits[12]};
          inc[msscl_pkg::C_LD_LFB] = {1'b0, samp.level_bits[4]};
          inc[msscl_pkg::C_LD_L1]  = {1'b0, samp.level_bits[3]};
          inc[msscl_pkg::C_LD_L2]  = {1'b0, samp.level_bits[5]};
          if (samp.level_bits[6]) begin
            if (samp.snoop_bits[4]) begin
              inc[msscl_pkg::C_LCL_HITM] = 2'd1;
            end else begin
              inc[msscl_pkg::C_LD_LLC] = 2'd1;
            end
          end
          inc[msscl_pkg::C_LCL_DRAM] = {1'b0, lcl_ram};
          inc[msscl_pkg::C_RMT_DRAM] = {1'b0, rmt_ram};
          if (samp.snoop_bits[2]) begin
            inc[msscl_pkg::C_LD_SHARED] = ram_hits;
          end else begin
            inc[msscl_pkg::C_LD_EXCL] = ram_hits;
          end
        end
        if (samp.level_bits[11:10] != 2'b00) begin
          if (samp.snoop_bits[2]) begin
            inc[msscl_pkg::C_RMT_HIT] = 2'd1;
          end else if (samp.snoop_bits[4]) begin
            inc[msscl_pkg::C_RMT_HITM] = 2'd1;
          end
        end
        inc[msscl_pkg::C_LD_MISS] = {1'b0, samp.level_bits[2]};
        if (!samp.maps_known) begin
          inc[msscl_pkg::C_NOMAP] = 2'd1;
          q_entry.status = msscl_pkg::ST_NOMAP;
        end
      end
    end else if (is_store) begin
      inc[msscl_pkg::C_STORE] = 2'd1;
      if (!samp.addr_known) begin
        inc[msscl_pkg::C_ST_NOADDR] = 2'd1;
        q_entry.status = msscl_pkg::ST_NOADDR;
      end else begin
        inc[msscl_pkg::C_ST_UNC]    = {1'b0, hit && samp.level_bits[13]};
        inc[msscl_pkg::C_ST_L1HIT]  = {1'b0, hit && samp.level_bits[3]};
        inc[msscl_pkg::C_ST_L1MISS] = {1'b0, samp.level_bits[2] && samp.level_bits[3]};
        if (!samp.maps_known) begin
          inc[msscl_pkg::C_NOMAP] = 2'd1;
          q_entry.status = msscl_pkg::ST_NOMAP;
        end
      end
    end else begin
      inc[msscl_pkg::C_NOPARSE] = 2'd1;
      q_entry.status = msscl_pkg::ST_NOPARSE;
    end

    q_entry.is_read    = (samp.func == msscl_pkg::FN_READ);
    q_entry.read_index = samp.read_index;
    q_entry.period     = samp.sample_period;
    q_entry.inc        = inc;
    q_entry.inc_hitm   = inc[msscl_pkg::C_LCL_HITM] + inc[msscl_pkg::C_RMT_HITM];
    q_entry.inc_missdn = inc[msscl_pkg::C_LCL_DRAM] + inc[msscl_pkg::C_RMT_DRAM]
                       + inc[msscl_pkg::C_RMT_HIT] + inc[msscl_pkg::C_RMT_HITM];
    q_entry.inc_total  = {1'b0, q_entry.inc_missdn}
                       + 3'(inc[msscl_pkg::C_LD_LFB]) + 3'(inc[msscl_pkg::C_LD_L1])
                       + 3'(inc[msscl_pkg::C_LD_L2]) + 3'(inc[msscl_pkg::C_LD_LLC])
                       + 3'(inc[msscl_pkg::C_LCL_HITM])
                       + 3'(inc[msscl_pkg::C_ST_L1HIT]) + 3'(inc[msscl_pkg::C_ST_L1MISS]);
  end

endmodule

`default_nettype wire

// ===== hdl/msscl_queue.sv =====
// Short flop queue of decoded items between the front end and the counter bank.
// Depends on msscl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msscl_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  msscl_pkg::q_entry_t  push_data,
  output logic                 push_ready,
  input  logic                 pop,
  output logic                 pop_valid,
  output msscl_pkg::q_entry_t  pop_data
);

  msscl_pkg::q_entry_t              mem [msscl_pkg::Q_DEPTH];
  logic [msscl_pkg::Q_AW-1:0]       wr_ptr;
  logic [msscl_pkg::Q_AW-1:0]       rd_ptr;
  logic [msscl_pkg::Q_CW-1:0]       count;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count != msscl_pkg::Q_CW'(msscl_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue fill count did not advance on push");

endmodule

`default_nettype wire

// ===== hdl/msscl_back.sv =====
// Back end: counter bank, derived sums, read mux and output register.
// Depends on msscl_pkg and msscl_out_if.
`timescale 1ns / 1ps
`default_nettype none

module msscl_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  msscl_pkg::q_entry_t  q_head,
  output logic                 q_pop,
  msscl_out_if.source          res
);

  msscl_pkg::cnt_t  cnt [msscl_pkg::NUM_CNT];
  msscl_pkg::cnt_t  period_sum;
  msscl_pkg::cnt_t  total_sum;
  msscl_pkg::cnt_t  hitm_sum;
  msscl_pkg::cnt_t  missdn_sum;
  msscl_pkg::cnt_t  rd_val;
  logic [63:0]      rd_wide;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [47:0]      out_value;
  logic             do_record;

  assign q_pop     = q_valid && (!out_valid || res.ready);
  assign do_record = q_pop && !q_head.is_read;

  always_comb begin
    case (q_head.read_index)
      msscl_pkg::RD_PERIOD: rd_val = period_sum;
      msscl_pkg::RD_TOTAL:  rd_val = total_sum;
      msscl_pkg::RD_HITM:   rd_val = hitm_sum;
      msscl_pkg::RD_MISSDN: rd_val = missdn_sum;
      default: begin
        if (q_head.read_index < msscl_pkg::ridx_t'(msscl_pkg::NUM_CNT)) begin
          rd_val = cnt[q_head.read_index];
        end else begin
          rd_val = '0;
        end
      end
    endcase
    rd_wide = 64'(rd_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < msscl_pkg::NUM_CNT; i++) begin
        cnt[i] <= '0;
      end
      period_sum <= '0;
      total_sum  <= '0;
      hitm_sum   <= '0;
      missdn_sum <= '0;
    end else if (do_record) begin
      for (int i = 0; i < msscl_pkg::NUM_CNT; i++) begin
        cnt[i] <= cnt[i] + msscl_pkg::cnt_t'(q_head.inc[i]);
      end
      period_sum <= period_sum + msscl_pkg::cnt_t'(q_head.period);
      total_sum  <= total_sum + msscl_pkg::cnt_t'(q_head.inc_total);
      hitm_sum   <= hitm_sum + msscl_pkg::cnt_t'(q_head.inc_hitm);
      missdn_sum <= missdn_sum + msscl_pkg::cnt_t'(q_head.inc_missdn);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.is_read) begin
        out_status <= msscl_pkg::ST_OK;
        out_value  <= rd_wide[47:0];
      end else begin
        out_status <= q_head.status;
        out_value  <= '0;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.read_value = out_value;

  a_entries_bump: assert property (@(posedge clk) disable iff (rst)
    do_record |=> (cnt[msscl_pkg::C_ENTRIES] == $past(cnt[msscl_pkg::C_ENTRIES]) + 1'b1))
    else $error("entry counter did not advance on record");

  a_hitm_sum: assert property (@(posedge clk) disable iff (rst)
    hitm_sum == msscl_pkg::cnt_t'(cnt[msscl_pkg::C_LCL_HITM] + cnt[msscl_pkg::C_RMT_HITM]))
    else $error("HITM sum out of step with its counters");

  a_missdn_sum: assert property (@(posedge clk) disable iff (rst)
    missdn_sum == msscl_pkg::cnt_t'(cnt[msscl_pkg::C_LCL_DRAM] + cnt[msscl_pkg::C_RMT_DRAM]
                                  + cnt[msscl_pkg::C_RMT_HIT] + cnt[msscl_pkg::C_RMT_HITM]))
    else $error("miss denominator out of step with its counters");

endmodule

`default_nettype wire

// ===== test/msscl_tb_pkg.sv =====
// Flag masks and the stimulus item type shared by the classifier testbench files.
// Depends on msscl_pkg only for the read index type.
`timescale 1ns / 1ps

package msscl_tb_pkg;

  localparam logic [4:0] OP_NA     = 5'b00001;
  localparam logic [4:0] OP_LOAD   = 5'b00010;
  localparam logic [4:0] OP_STORE  = 5'b00100;
  localparam logic [4:0] OP_PFETCH = 5'b01000;
  localparam logic [4:0] OP_EXEC   = 5'b10000;

  localparam logic [13:0] LV_NA     = 14'h0001;
  localparam logic [13:0] LV_HIT    = 14'h0002;
  localparam logic [13:0] LV_MISS   = 14'h0004;
  localparam logic [13:0] LV_L1     = 14'h0008;
  localparam logic [13:0] LV_LFB    = 14'h0010;
  localparam logic [13:0] LV_L2     = 14'h0020;
  localparam logic [13:0] LV_L3     = 14'h0040;
  localparam logic [13:0] LV_LOCRAM = 14'h0080;
  localparam logic [13:0] LV_RRAM1  = 14'h0100;
  localparam logic [13:0] LV_RRAM2  = 14'h0200;
  localparam logic [13:0] LV_RCCE1  = 14'h0400;
  localparam logic [13:0] LV_RCCE2  = 14'h0800;
  localparam logic [13:0] LV_IO     = 14'h1000;
  localparam logic [13:0] LV_UNC    = 14'h2000;
  localparam logic [13:0] LV_REMRAM = LV_RRAM1 | LV_RRAM2;
  localparam logic [13:0] LV_REMCCE = LV_RCCE1 | LV_RCCE2;

  localparam logic [4:0] SN_NA   = 5'b00001;
  localparam logic [4:0] SN_NONE = 5'b00010;
  localparam logic [4:0] SN_HIT  = 5'b00100;
  localparam logic [4:0] SN_MISS = 5'b01000;
  localparam logic [4:0] SN_HITM = 5'b10000;

  localparam logic [1:0] LK_NA     = 2'b01;
  localparam logic [1:0] LK_LOCKED = 2'b10;

  typedef struct packed {
    logic                func;
    logic [4:0]          op;
    logic [13:0]         level;
    logic [4:0]          snoop;
    logic [1:0]          lock;
    logic                addr_known;
    logic                maps_known;
    logic [31:0]         period;
    msscl_pkg::ridx_t    ridx;
  } sample_item_t;

endpackage

// ===== test/msscl_count_checker.sv =====
// Watches the sample and result channels, classifies each accepted sample into its
// own counter bank and compares every result with the oldest outstanding one.
// Depends on msscl_pkg, msscl_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps

module msscl_count_checker
  import msscl_pkg::*;
  import msscl_tb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  msscl_in_if   samp_mon,
  msscl_out_if  res_mon,
  output int    fail_count,
  output int    pending,
  output int    n_records,
  output int    n_reads,
  output int    n_flagged
);

  typedef struct packed {
    status_t status;
    cnt_t    value;
  } result_t;

  cnt_t    ev_cnt [NUM_CNT];
  cnt_t    period_total;
  result_t results_due [$];

  function automatic void bump(int unsigned slot);
    ev_cnt[slot] = ev_cnt[slot] + 1'b1;
  endfunction

  function automatic status_t classify_sample(
    logic [4:0] op, logic [13:0] lvl, logic [4:0] snp, logic [1:0] lck,
    logic addr, logic maps, logic [31:0] per
  );
    bump(C_ENTRIES);
    period_total = period_total + per;
    if (|(lck & LK_LOCKED)) bump(C_LOCKS);
    if (|(op & OP_LOAD)) begin
      bump(C_LOAD);
      if (!addr) begin
        bump(C_LD_NOADDR);
        return ST_NOADDR;
      end
      if (|(lvl & LV_HIT)) begin
        if (|(lvl & LV_UNC)) bump(C_LD_UNC);
        if (|(lvl & LV_IO)) bump(C_LD_IO);
        if (|(lvl & LV_LFB)) bump(C_LD_LFB);
        if (|(lvl & LV_L1)) bump(C_LD_L1);
        if (|(lvl & LV_L2)) bump(C_LD_L2);
        if (|(lvl & LV_L3)) bump(|(snp & SN_HITM) ? C_LCL_HITM : C_LD_LLC);
        if (|(lvl & LV_LOCRAM)) begin
          bump(C_LCL_DRAM);
          bump(|(snp & SN_HIT) ? C_LD_SHARED : C_LD_EXCL);
        end
        if (|(lvl & LV_REMRAM)) begin
          bump(C_RMT_DRAM);
          bump(|(snp & SN_HIT) ? C_LD_SHARED : C_LD_EXCL);
        end
      end
      if (|(lvl & LV_REMCCE)) begin
        if (|(snp & SN_HIT)) bump(C_RMT_HIT);
        else if (|(snp & SN_HITM)) bump(C_RMT_HITM);
      end
      if (|(lvl & LV_MISS)) bump(C_LD_MISS);
    end else if (|(op & OP_STORE)) begin
      bump(C_STORE);
      if (!addr) begin
        bump(C_ST_NOADDR);
        return ST_NOADDR;
      end
      if (|(lvl & LV_HIT)) begin
        if (|(lvl & LV_UNC)) bump(C_ST_UNC);
        if (|(lvl & LV_L1)) bump(C_ST_L1HIT);
      end
      if (|(lvl & LV_MISS) && |(lvl & LV_L1)) bump(C_ST_L1MISS);
    end else begin
      bump(C_NOPARSE);
      return ST_NOPARSE;
    end
    if (!maps) begin
      bump(C_NOMAP);
      return ST_NOMAP;
    end
    return ST_OK;
  endfunction

  function automatic cnt_t counter_value(ridx_t idx);
    cnt_t missdn;
    missdn = ev_cnt[C_LCL_DRAM] + ev_cnt[C_RMT_DRAM] + ev_cnt[C_RMT_HIT] + ev_cnt[C_RMT_HITM];
    if (idx < NUM_CNT) return ev_cnt[idx];
    case (idx)
      RD_PERIOD: return period_total;
      RD_TOTAL:  return missdn + ev_cnt[C_LD_LFB] + ev_cnt[C_LD_L1] + ev_cnt[C_LD_L2] +
                        ev_cnt[C_LD_LLC] + ev_cnt[C_LCL_HITM] + ev_cnt[C_ST_L1HIT] +
                        ev_cnt[C_ST_L1MISS];
      RD_HITM:   return ev_cnt[C_LCL_HITM] + ev_cnt[C_RMT_HITM];
      RD_MISSDN: return missdn;
      default:   return '0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [47:0] want_v, logic [47:0] got_v);
    if (fail_count < 40)
      $display("%0t ns: %s: expected %0h, got %0h", $time, what, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      foreach (ev_cnt[i]) ev_cnt[i] = '0;
      period_total = '0;
      results_due.delete();
      fail_count = 0;
      n_records = 0;
      n_reads = 0;
      n_flagged = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.status = status_t'(res_mon.status);
        got.value  = res_mon.read_value;
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, got.value);
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status) report_mismatch("status", want.status, got.status);
          if (got.value != want.value) report_mismatch("read_value", want.value, got.value);
        end
      end
      if (samp_mon.valid && samp_mon.ready) begin
        if (samp_mon.func == FN_READ) begin
          want.status = ST_OK;
          want.value  = counter_value(samp_mon.read_index);
          n_reads++;
        end else begin
          want.status = classify_sample(samp_mon.op_bits, samp_mon.level_bits,
                                        samp_mon.snoop_bits, samp_mon.lock_bits,
                                        samp_mon.addr_known, samp_mon.maps_known,
                                        samp_mon.sample_period);
          want.value  = '0;
          n_records++;
          if (want.status != ST_OK) n_flagged++;
        end
        results_due.push_back(want);
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== test/memory_sample_source_classifier_core_tb.sv =====
// Top of the classifier testbench: clock, reset, bursty sample traffic and a
// stalling result sink; checking is done by msscl_count_checker beside the block.
// Depends on msscl_pkg, msscl_tb_pkg, the channel interfaces and the checker.
`timescale 1ns / 1ps

module memory_sample_source_classifier_core_tb;
  import msscl_pkg::*;
  import msscl_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1050;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst;
  int       cycle_count = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_left = 0;
  int       fail_count;
  int       pending;
  int       n_records;
  int       n_reads;
  int       n_flagged;

  msscl_in_if  samp_ch ();
  msscl_out_if res_ch ();

  memory_sample_source_classifier_core u_dut (
    .clk  (clk),
    .rst  (rst),
    .samp (samp_ch),
    .res  (res_ch)
  );

  msscl_count_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .samp_mon   (samp_ch),
    .res_mon    (res_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .n_records  (n_records),
    .n_reads    (n_reads),
    .n_flagged  (n_flagged)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(32, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS:   res_ch.ready <= 1'b1;
        RX_COIN:     res_ch.ready <= 1'($urandom);
        RX_PERIODIC: res_ch.ready <= (cycle_count % 7) < 4;
        default:     res_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic sample_item_t mk_record(logic [4:0] op, logic [13:0] lvl, logic [4:0] snp,
                                             logic [1:0] lck, logic addr, logic maps,
                                             logic [31:0] per);
    sample_item_t it;
    it.func = FN_RECORD;
    it.op = op;
    it.level = lvl;
    it.snoop = snp;
    it.lock = lck;
    it.addr_known = addr;
    it.maps_known = maps;
    it.period = per;
    it.ridx = ridx_t'($urandom);
    return it;
  endfunction

  // Fields other than the index carry noise; a read must ignore them.
  function automatic sample_item_t mk_read(ridx_t idx);
    sample_item_t it;
    it = mk_record(5'($urandom), 14'($urandom), 5'($urandom), 2'($urandom),
                   1'($urandom), 1'($urandom), $urandom);
    it.func = FN_READ;
    it.ridx = idx;
    return it;
  endfunction

  function automatic sample_item_t gen_record();
    int unsigned sel;
    logic [4:0]  op;
    logic [13:0] lvl;
    logic [31:0] per;
    sel = $urandom_range(0, 9);
    if (sel < 4) op = 5'($urandom) | OP_LOAD;
    else if (sel < 7) op = (5'($urandom) | OP_STORE) & ~OP_LOAD;
    else if (sel < 8) op = 5'($urandom) & ~(OP_LOAD | OP_STORE);
    else op = 5'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      lvl = 14'($urandom);
    end else begin
      lvl = (14'd1 << $urandom_range(2, 13)) | (14'd1 << $urandom_range(0, 13));
      if ($urandom_range(0, 3) != 0) lvl = lvl | LV_HIT;
    end
    sel = $urandom_range(0, 9);
    per = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    return mk_record(op, lvl, 5'($urandom), 2'($urandom), $urandom_range(0, 7) != 0,
                     $urandom_range(0, 7) != 0, per);
  endfunction

  task automatic send_sample(sample_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        samp_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    samp_ch.valid         <= 1'b1;
    samp_ch.func          <= it.func;
    samp_ch.op_bits       <= it.op;
    samp_ch.level_bits    <= it.level;
    samp_ch.snoop_bits    <= it.snoop;
    samp_ch.lock_bits     <= it.lock;
    samp_ch.addr_known    <= it.addr_known;
    samp_ch.maps_known    <= it.maps_known;
    samp_ch.sample_period <= it.period;
    samp_ch.read_index    <= it.ridx;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    samp_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst                   <= 1'b1;
    samp_ch.valid         <= 1'b0;
    samp_ch.func          <= FN_RECORD;
    samp_ch.op_bits       <= '0;
    samp_ch.level_bits    <= '0;
    samp_ch.snoop_bits    <= '0;
    samp_ch.lock_bits     <= '0;
    samp_ch.addr_known    <= 1'b0;
    samp_ch.maps_known    <= 1'b0;
    samp_ch.sample_period <= '0;
    samp_ch.read_index    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_sample(mk_read(RD_TOTAL));
    send_sample(mk_record(OP_LOAD, LV_HIT | LV_L1, SN_NONE, LK_NA, 1'b1, 1'b1, 32'd0));
    send_sample(mk_record(5'h1F, 14'h3FFF, 5'h1F, 2'b11, 1'b1, 1'b1, 32'hFFFF_FFFF));
    send_sample(mk_record(OP_LOAD, LV_HIT | LV_L3, SN_HITM, 2'b00, 1'b1, 1'b1, 32'd7));
    send_sample(mk_record(OP_LOAD, LV_HIT | LV_L3 | LV_LFB | LV_L2, 5'd0, LK_LOCKED,
                          1'b1, 1'b1, 32'd1));
    send_sample(mk_record(OP_LOAD, LV_HIT | LV_LOCRAM | LV_IO | LV_UNC, SN_HIT, LK_NA,
                          1'b1, 1'b1, 32'd100));
    send_sample(mk_record(OP_LOAD, LV_HIT | LV_RRAM2, SN_NONE, LK_NA, 1'b1, 1'b1, 32'd3));
    send_sample(mk_record(OP_LOAD, LV_RCCE1, SN_HIT | SN_HITM, LK_NA, 1'b1, 1'b1, 32'd5));
    send_sample(mk_record(OP_LOAD, LV_RCCE2 | LV_MISS, SN_HITM, LK_NA, 1'b1, 1'b1, 32'd9));
    send_sample(mk_record(OP_LOAD | OP_STORE, LV_HIT | LV_L1 | LV_MISS, SN_MISS, LK_NA,
                          1'b1, 1'b1, 32'd2));
    send_sample(mk_record(OP_LOAD, LV_HIT | LV_L1, SN_NA, LK_LOCKED, 1'b0, 1'b1, 32'd4));
    send_sample(mk_record(OP_STORE, LV_HIT | LV_L1, SN_NA, LK_NA, 1'b0, 1'b0, 32'd4));
    send_sample(mk_record(OP_STORE, LV_HIT | LV_UNC | LV_L1, SN_NONE, LK_NA, 1'b1, 1'b1,
                          32'd6));
    send_sample(mk_record(OP_STORE | OP_PFETCH, LV_MISS | LV_L1, SN_NONE, LK_NA, 1'b1, 1'b1,
                          32'd8));
    send_sample(mk_record(OP_PFETCH, LV_HIT | LV_L1, SN_NONE, LK_LOCKED, 1'b1, 1'b1, 32'd1));
    send_sample(mk_record(OP_NA | OP_EXEC, LV_NA, SN_NA, LK_NA, 1'b0, 1'b0, 32'd1));
    send_sample(mk_record(OP_LOAD, LV_HIT | LV_L2, SN_NONE, LK_NA, 1'b1, 1'b0, 32'd1));
    send_sample(mk_record(OP_STORE, LV_MISS, SN_NONE, LK_NA, 1'b1, 1'b0, 32'hFFFF_FFFF));
    send_sample(mk_read(ridx_t'(C_ENTRIES)));
    send_sample(mk_read(ridx_t'(C_NOMAP)));
    send_sample(mk_read(RD_PERIOD));
    send_sample(mk_read(RD_TOTAL));
    send_sample(mk_read(RD_HITM));
    send_sample(mk_read(RD_MISSDN));
    send_sample(mk_read(ridx_t'(29)));
    send_sample(mk_read(ridx_t'(31)));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 3) == 0) send_sample(mk_read(ridx_t'($urandom)));
      else send_sample(gen_record());
    end
    wait_drained();
    repeat (6) @(posedge clk);
    @(negedge clk);

    $display("covered %0d recorded samples (%0d with a non-ok status) and %0d counter reads",
             n_records, n_flagged, n_reads);
    if (fail_count == 0 && pending == 0) begin
      $display("memory_sample_source_classifier_core: match");
    end else begin
      $display("memory_sample_source_classifier_core: mismatch");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("memory_sample_source_classifier_core: mismatch");
    $finish;
  end

endmodule

// ===== memory_sample_source_classifier_core.f =====
hdl/msscl_pkg.sv
hdl/msscl_ifs.sv
hdl/msscl_front.sv
hdl/msscl_queue.sv
hdl/msscl_back.sv
hdl/memory_sample_source_classifier_core.sv
test/msscl_tb_pkg.sv
test/msscl_count_checker.sv
test/memory_sample_source_classifier_core_tb.sv
